### hw/rtl/sorted_priority_list_keyed_removal_unit_macros.svh
// Assertion macros for the sorted priority list with keyed removal.
`ifndef SORTED_PRIORITY_LIST_KEYED_REMOVAL_UNIT_MACROS_SVH
`define SORTED_PRIORITY_LIST_KEYED_REMOVAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SPL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spl assertion failed");

// Next-cycle implication, checked outside reset.
`define SPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spl assertion failed");

`else

`define SPL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/spl_pkg.sv
// Shared codes and field widths of the sorted priority list.
`timescale 1ns / 1ps

package spl_pkg;

  // Field widths on the stream ports
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned PRIO_IO_W = 32;
  localparam int unsigned IDX_IO_W  = 5;
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned M_TDATA_W = 112;

  // Command codes (code 3 is unused and answers not found)
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

### hw/rtl/sorted_priority_list_keyed_removal_unit.sv
// Sorted priority list with keyed removal, held in one synchronous entry memory.
`timescale 1ns / 1ps
`include "sorted_priority_list_keyed_removal_unit_macros.svh"

// Command beats enter on the s_axis channel (tuser = command, tdata = key and
// priority); one result beat per command leaves on m_axis (tuser = status,
// tdata = key, priority, position, occupancy).
// Entries live in one memory, read one address per cycle through a registered
// read port, and are moved one per cycle by a scan engine.
// Insert: scans from the tail toward the head, moving each lower-priority
// entry one slot down, then writes the new entry (a full table answers full;
// an empty table takes the new entry straight into slot 0).
// Remove: scans from the head, finds the first matching key and moves every
// later entry one slot up, scanning every entry held.
// Clear empties the list; the unused command answers not found.
// Reset empties the list at once; memory contents are not cleared.
// A finished result sits in the output register while the next command is
// taken; a stalled receiver holds the result, and the engine waits before
// loading a further result until the register is free.
module sorted_priority_list_keyed_removal_unit #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] command
  input  logic [spl_pkg::CMD_W-1:0]     s_axis_tuser,
  // [63:0] key, [95:64] priority_req
  input  logic [spl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] status
  output logic [spl_pkg::STATUS_W-1:0]  m_axis_tuser,
  // [63:0] out_key, [95:64] out_priority, [100:96] position,
  // [105:101] occupancy, [111:106] zero
  output logic [spl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import spl_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = PRIORITY_BITS;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PW-1:0]    prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_REM,
    S_OUT
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          didx_q, didx_d;
  logic                   found_q, found_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [PW-1:0]          prio_q, prio_d;
  status_e                res_status_q, res_status_d;
  logic [KEY_W-1:0]       res_key_q, res_key_d;
  logic [PRIO_IO_W-1:0]   res_prio_q, res_prio_d;
  logic [IW-1:0]          res_pos_q, res_pos_d;
  logic                   m_valid_q, m_valid_d;
  logic [STATUS_W-1:0]    m_tuser_q, m_tuser_d;
  logic [M_TDATA_W-1:0]   m_tdata_q, m_tdata_d;

  // Entry memory
  entry_t                 mem [CAPACITY];
  logic                   mem_we;
  logic [IW-1:0]          mem_wa;
  entry_t                 mem_wd;
  logic [IW-1:0]          mem_ra;
  entry_t                 mem_rd_q;

  // Helpers
  logic                   s_accept;
  cmd_e                   in_cmd;
  logic [KEY_W-1:0]       in_key;
  logic [PW+PRIO_IO_W-1:0] in_prio_wide;
  logic [PW-1:0]          in_prio;
  logic [CW-1:0]          count_m1;
  logic [IW-1:0]          last_idx;
  logic                   full;
  logic [IW-1:0]          didx_p1;
  logic [IW-1:0]          didx_m1;
  logic [PW+PRIO_IO_W-1:0] rd_prio_wide;
  logic [IW+IDX_IO_W-1:0] pos_wide;
  logic [CW+IDX_IO_W-1:0] occ_wide;
  logic                   rem_hit;
  logic                   rem_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_key        = s_axis_tdata[KEY_W-1:0];
  // Priority is cut to PW bits (zero-extended when PW is wider than 32)
  assign in_prio_wide  = {{PW{1'b0}}, s_axis_tdata[KEY_W +: PRIO_IO_W]};
  assign in_prio       = in_prio_wide[PW-1:0];

  assign count_m1 = count_q - CW'(1);
  assign last_idx = count_m1[IW-1:0];
  assign full     = (count_q == CW'(CAPACITY));
  assign didx_p1  = didx_q + IW'(1);
  assign didx_m1  = didx_q - IW'(1);

  // Stored priority sign-extended to the 32-bit output field
  assign rd_prio_wide = {{PRIO_IO_W{mem_rd_q.prio[PW-1]}}, mem_rd_q.prio};

  // Index fields masked to the 5-bit port width
  assign pos_wide = {{IDX_IO_W{1'b0}}, res_pos_q};
  assign occ_wide = {{IDX_IO_W{1'b0}}, count_q};

  assign rem_hit  = !found_q && (mem_rd_q.key == key_q);
  assign rem_last = (didx_q == last_idx);

  // Scan engine and result staging
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    didx_d       = didx_q;
    found_d      = found_q;
    key_d        = key_q;
    prio_d       = prio_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_prio_d   = res_prio_q;
    res_pos_d    = res_pos_q;
    m_valid_d    = m_valid_q;
    m_tuser_d    = m_tuser_q;
    m_tdata_d    = m_tdata_q;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '{key: key_q, prio: prio_q};
    mem_ra       = didx_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          key_d      = in_key;
          prio_d     = in_prio;
          res_key_d  = '0;
          res_prio_d = '0;
          res_pos_d  = '0;
          case (in_cmd)
            CMD_INSERT: begin
              res_status_d = ST_INSERTED;
              if (full) begin
                res_status_d = ST_FULL;
                state_d      = S_OUT;
              end else if (count_q == '0) begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = '{key: in_key, prio: in_prio};
                count_d = count_q + CW'(1);
                state_d = S_OUT;
              end else begin
                mem_ra  = last_idx;
                didx_d  = last_idx;
                state_d = S_INS;
              end
            end
            CMD_REMOVE: begin
              res_status_d = ST_NOT_FOUND;
              if (count_q == '0) begin
                state_d = S_OUT;
              end else begin
                mem_ra  = '0;
                didx_d  = '0;
                found_d = 1'b0;
                state_d = S_REM;
              end
            end
            CMD_CLEAR: begin
              res_status_d = ST_INSERTED;
              count_d      = '0;
              state_d      = S_OUT;
            end
            default: begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_OUT;
            end
          endcase
        end
      end

      // Walk toward the head; entries below the new priority move down a slot
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = didx_p1;
        if ($signed(mem_rd_q.prio) >= $signed(prio_q)) begin
          res_pos_d = didx_p1;
          count_d   = count_q + CW'(1);
          state_d   = S_OUT;
        end else begin
          mem_wd = mem_rd_q;
          if (didx_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            mem_ra = didx_m1;
            didx_d = didx_m1;
          end
        end
      end

      // New entry lands at the head
      S_INS_HEAD: begin
        mem_we    = 1'b1;
        mem_wa    = '0;
        res_pos_d = '0;
        count_d   = count_q + CW'(1);
        state_d   = S_OUT;
      end

      // Walk from the head; after the match, entries move up a slot
      S_REM: begin
        if (rem_hit) begin
          found_d      = 1'b1;
          res_status_d = ST_REMOVED;
          res_key_d    = mem_rd_q.key;
          res_prio_d   = rd_prio_wide[PRIO_IO_W-1:0];
          res_pos_d    = didx_q;
        end
        if (found_q) begin
          mem_we = 1'b1;
          mem_wa = didx_m1;
          mem_wd = mem_rd_q;
        end
        if (rem_last) begin
          if (found_q || rem_hit) begin
            count_d = count_m1;
          end
          state_d = S_OUT;
        end else begin
          mem_ra = didx_p1;
          didx_d = didx_p1;
        end
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_tuser_d = res_status_q;
          m_tdata_d = {6'b0, occ_wide[IDX_IO_W-1:0], pos_wide[IDX_IO_W-1:0],
                       res_prio_q, res_key_q};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      didx_q       <= '0;
      found_q      <= 1'b0;
      m_valid_q    <= 1'b0;
      key_q        <= '0;
      prio_q       <= '0;
      res_status_q <= ST_INSERTED;
      res_key_q    <= '0;
      res_prio_q   <= '0;
      res_pos_q    <= '0;
      m_tuser_q    <= '0;
      m_tdata_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      didx_q       <= didx_d;
      found_q      <= found_d;
      m_valid_q    <= m_valid_d;
      key_q        <= key_d;
      prio_q       <= prio_d;
      res_status_q <= res_status_d;
      res_key_q    <= res_key_d;
      res_prio_q   <= res_prio_d;
      res_pos_q    <= res_pos_d;
      m_tuser_q    <= m_tuser_d;
      m_tdata_q    <= m_tdata_d;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tdata  = m_tdata_q;

  // Checks
  `SPL_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY))
  `SPL_ASSERT_IMPL(a_scan_in_range, clk_i, rst_ni,
                   (state_q == S_INS) || (state_q == S_REM), didx_q < count_q)
  `SPL_ASSERT_NEXT(a_full_keeps_count, clk_i, rst_ni,
                   s_accept && (in_cmd == CMD_INSERT) && full, count_q == $past(count_q))
  `SPL_ASSERT_IMPL(a_result_from_out, clk_i, rst_ni,
                   $rose(m_valid_q), $past(state_q) == S_OUT)

endmodule
